// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes, the pipeline item record and saturation helpers shared by the
// stages of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_COMPARE  = 4'd10
  } op_t;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  // One item as it moves down the pipeline.
  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               less;
    logic               equal;
    logic               greater;
    logic [31:0]        res;
    logic               ovf;
    logic               dz;
    logic               neg;
    logic signed [63:0] prod;
    logic [63:0]        rem;
    logic [63:0]        den;
    logic [31:0]        quo;
    logic               dsat;
  } item_t;

  // Apply a sign to a magnitude and saturate; returns {overflow, value}.
  function automatic logic [32:0] sat_mag(logic [63:0] mag, logic neg);
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) return {1'b1, MIN32};
      return {1'b0, 32'(32'd0 - mag[31:0])};
    end
    if (mag > 64'h0000_0000_7FFF_FFFF) return {1'b1, MAX32};
    return {1'b0, mag[31:0]};
  endfunction

  // Saturate a 33-bit signed sum; returns {overflow, value}.
  function automatic logic [32:0] sat_sum(logic [32:0] s);
    if (s[32] != s[31]) return {1'b1, (s[32] ? MIN32 : MAX32)};
    return {1'b0, s[31:0]};
  endfunction

endpackage

// ===== src/fpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// First stage: flags, the simple operations, and divider operand setup.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          op,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  output logic                out_valid,
  input  logic                out_ready,
  output fpa_pkg::item_t      out_item
);

  fpa_pkg::item_t item_next;
  logic [32:0] mag_a;
  logic [32:0] mag_b;
  logic [63:0] num;
  logic [63:0] fi;
  logic [32:0] sat;

  always_comb begin
    mag_a = operand_a[31] ? 33'(~{1'b1, operand_a} + 33'd1) : {1'b0, operand_a};
    mag_b = operand_b[31] ? 33'(~{1'b1, operand_b} + 33'd1) : {1'b0, operand_b};
    num   = ({31'd0, mag_a} << (FRAC_BITS + 1)) + {31'd0, mag_b};
    fi    = {31'd0, mag_a} << FRAC_BITS;

    item_next         = '0;
    item_next.op      = op;
    item_next.a       = operand_a;
    item_next.b       = operand_b;
    item_next.less    = operand_a < operand_b;
    item_next.equal   = operand_a == operand_b;
    item_next.greater = operand_a > operand_b;
    item_next.neg     = operand_a[31] ^ operand_b[31];
    item_next.dz      = (op == fpa_pkg::OP_DIV) && (operand_b == 32'sd0);
    item_next.rem     = num;
    item_next.den     = {30'd0, mag_b, 1'b0};
    // quotient of 2^32 or more always saturates
    item_next.dsat    = {32'd0, num[63:32]} >= {30'd0, mag_b, 1'b0};

    sat = '0;
    case (op)
      fpa_pkg::OP_ADD: sat = fpa_pkg::sat_sum({operand_a[31], operand_a}
                                              + {operand_b[31], operand_b});
      fpa_pkg::OP_SUB: sat = fpa_pkg::sat_sum({operand_a[31], operand_a}
                                              - {operand_b[31], operand_b});
      fpa_pkg::OP_INC: sat = fpa_pkg::sat_sum({operand_a[31], operand_a} + 33'd1);
      fpa_pkg::OP_DEC: sat = fpa_pkg::sat_sum({operand_a[31], operand_a} - 33'd1);
      fpa_pkg::OP_MIN: sat = {1'b0, (operand_a < operand_b) ? operand_a : operand_b};
      fpa_pkg::OP_MAX: sat = {1'b0, (operand_a > operand_b) ? operand_a : operand_b};
      fpa_pkg::OP_TO_INT: sat = {1'b0, 32'(operand_a >>> FRAC_BITS)};
      fpa_pkg::OP_FROM_INT: sat = fpa_pkg::sat_mag(fi, operand_a[31]);
      default: sat = '0;
    endcase
    item_next.ovf = sat[32];
    item_next.res = sat[31:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== src/fpa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_mul
// Multiplier stage: full 64-bit signed product of the raw operands.
// ----------------------------------------------------------------------------
module fpa_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::item_t out_item
);

  fpa_pkg::item_t item_next;

  always_comb begin
    item_next      = in_item;
    item_next.prod = 64'(in_item.a) * 64'(in_item.b);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== src/fpa_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_round
// Product scaling: drop the fraction bits, round half away from zero, saturate.
// ----------------------------------------------------------------------------
module fpa_round #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::item_t out_item
);

  fpa_pkg::item_t item_next;
  logic [63:0] mag;
  logic [63:0] scaled;
  logic [32:0] sat;

  always_comb begin
    mag    = in_item.prod[63] ? 64'(-in_item.prod) : 64'(in_item.prod);
    scaled = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    sat    = fpa_pkg::sat_mag(scaled, in_item.prod[63]);
    item_next = in_item;
    if (in_item.op == fpa_pkg::OP_MUL) begin
      item_next.res = sat[31:0];
      item_next.ovf = sat[32];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== src/fpa_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring-division stage: settles quotient bit BIT.
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int BIT = 31
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::item_t out_item
);

  fpa_pkg::item_t item_next;
  logic [63:0] trial;

  always_comb begin
    trial     = in_item.den << BIT;
    item_next = in_item;
    if (in_item.rem >= trial) begin
      item_next.rem      = in_item.rem - trial;
      item_next.quo[BIT] = 1'b1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== src/fpa_final.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_final
// Output stage: resolve the divide result and drive the result ports.
// ----------------------------------------------------------------------------
module fpa_final (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::item_t     in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               overflow,
  output logic               div_zero
);

  logic [31:0] res_next;
  logic        ovf_next;
  logic [32:0] sat;

  always_comb begin
    sat      = fpa_pkg::sat_mag({32'd0, in_item.quo}, in_item.neg);
    res_next = in_item.res;
    ovf_next = in_item.ovf;
    if (in_item.op == fpa_pkg::OP_DIV) begin
      if (in_item.dz) begin
        // zero divisor: saturate by the dividend's sign, 0/0 gives 0
        ovf_next = in_item.a != 32'sd0;
        res_next = (in_item.a == 32'sd0) ? 32'd0 :
                   (in_item.a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32);
      end else if (in_item.dsat) begin
        ovf_next = 1'b1;
        res_next = in_item.neg ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
      end else begin
        ovf_next = sat[32];
        res_next = sat[31:0];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result   <= res_next;
      less     <= in_item.less;
      equal    <= in_item.equal;
      greater  <= in_item.greater;
      overflow <= ovf_next;
      div_zero <= in_item.dz;
    end
  end

endmodule

// ===== src/fixed_point_alu_q24_8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU on raw 32-bit operands with FRAC_BITS fraction bits.
//
// Input channel in_valid/in_ready carries op, operand_a and operand_b; output
// channel out_valid/out_ready carries result and the less, equal, greater,
// overflow and div_zero flags. Every transfer in gives exactly one transfer out.
// The path is the same for every op: operand setup, one 32x32 multiply stage,
// product rounding, 32 restoring-division stages (one quotient bit each) and
// an output register. Throughput is one item per cycle while out_ready is high.
// Each stage holds its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up and a stalled receiver holds
// the pipeline without dropping or repeating items. in_ready stays high unless
// all 36 stages are full and out_ready is low. Reset clears every valid bit;
// the block holds no other state.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               overflow,
  output logic               div_zero
);

  localparam int DIV_STAGES = 32;

  fpa_pkg::item_t front_item;
  fpa_pkg::item_t mul_item;
  logic front_valid, front_ready;
  logic mul_valid, mul_ready;

  fpa_pkg::item_t div_item  [0:DIV_STAGES];
  logic           div_valid [0:DIV_STAGES];
  logic           div_ready [0:DIV_STAGES];

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst,
    .in_valid, .in_ready,
    .op, .operand_a, .operand_b,
    .out_valid(front_valid), .out_ready(front_ready), .out_item(front_item)
  );

  fpa_mul u_mul (
    .clk, .rst,
    .in_valid(front_valid), .in_ready(front_ready), .in_item(front_item),
    .out_valid(mul_valid), .out_ready(mul_ready), .out_item(mul_item)
  );

  fpa_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk, .rst,
    .in_valid(mul_valid), .in_ready(mul_ready), .in_item(mul_item),
    .out_valid(div_valid[0]), .out_ready(div_ready[0]), .out_item(div_item[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fpa_div_step #(.BIT(DIV_STAGES - 1 - k)) u_step (
      .clk, .rst,
      .in_valid(div_valid[k]), .in_ready(div_ready[k]), .in_item(div_item[k]),
      .out_valid(div_valid[k+1]), .out_ready(div_ready[k+1]),
      .out_item(div_item[k+1])
    );
  end

  fpa_final u_final (
    .clk, .rst,
    .in_valid(div_valid[DIV_STAGES]), .in_ready(div_ready[DIV_STAGES]),
    .in_item(div_item[DIV_STAGES]),
    .out_valid, .out_ready,
    .result, .less, .equal, .greater, .overflow, .div_zero
  );

endmodule

// ===== tb/fixed_point_alu_q24_8_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_tb
// Drives opcode/operand items into the fixed-point ALU and checks every result
// and flag against an exact integer predictor. A directed table covers limits,
// every opcode, divide by zero and an undefined opcode; random items follow with
// random idling on both channels and a drain pause in the middle.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_tb;

  localparam int FRAC = 8;
  localparam int LATENCY = 36;
  localparam int N_RANDOM = 1400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] res;
    logic lt, eq, gt, ovf, dz;
  } alu_out_t;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 typed;
    alu_out_t           want;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] op = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result;
  logic less, equal, greater, overflow, div_zero;

  alu_out_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
    .out_ready(out_ready), .result(result), .less(less), .equal(equal),
    .greater(greater), .overflow(overflow), .div_zero(div_zero)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [31:0] saturate(logic signed [65:0] v, ref logic ovf);
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return fpa_pkg::MAX32;
    end
    if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return fpa_pkg::MIN32;
    end
    return v[31:0];
  endfunction

  function automatic alu_out_t compute_alu(logic [3:0] o, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_out_t r;
    logic signed [65:0] wa, wb, p, v;
    logic [65:0] num, den, q, m;
    logic ovf;
    wa = a;
    wb = b;
    ovf = 1'b0;
    r.dz = 1'b0;
    r.res = '0;
    case (o)
      fpa_pkg::OP_ADD: r.res = saturate(wa + wb, ovf);
      fpa_pkg::OP_SUB: r.res = saturate(wa - wb, ovf);
      fpa_pkg::OP_MUL: begin
        p = wa * wb;
        m = ((p < 0 ? -p : p) + (66'd1 << (FRAC - 1))) >> FRAC;
        v = (p < 0) ? -$signed(m) : $signed(m);
        r.res = saturate(v, ovf);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          if (a > 0) begin
            r.res = fpa_pkg::MAX32;
            ovf = 1'b1;
          end else if (a < 0) begin
            r.res = fpa_pkg::MIN32;
            ovf = 1'b1;
          end
        end else begin
          num = (wa < 0 ? -wa : wa) << (FRAC + 1);
          den = wb < 0 ? -wb : wb;
          q = (num + den) / (den << 1);
          v = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
          r.res = saturate(v, ovf);
        end
      end
      fpa_pkg::OP_INC: r.res = saturate(wa + 1, ovf);
      fpa_pkg::OP_DEC: r.res = saturate(wa - 1, ovf);
      fpa_pkg::OP_MIN: r.res = (a < b) ? a : b;
      fpa_pkg::OP_MAX: r.res = (a > b) ? a : b;
      fpa_pkg::OP_TO_INT: r.res = a >>> FRAC;
      fpa_pkg::OP_FROM_INT: r.res = saturate(wa * (66'sd1 <<< FRAC), ovf);
      default: r.res = '0;
    endcase
    r.ovf = ovf;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return fpa_pkg::MAX32 - $urandom_range(0, 3);
      1: return fpa_pkg::MIN32 + $urandom_range(0, 3);
      2: return $signed(32'($urandom_range(0, 2048))) - 1024;
      3: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      4: return $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  // Send one transfer; a held valid is never dropped between back-to-back items.
  task automatic send_item(logic [3:0] o, logic signed [31:0] a, logic signed [31:0] b,
                           alu_out_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(want);
    @(negedge clk);
  endtask

  // Receiver idling.
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Check every output transfer against the oldest expectation.
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, result);
      end else begin
        e = pending_q.pop_front();
        if (result !== e.res) begin
          errors++;
          $display("%0t: result expected %h actual %h", $time, e.res, result);
        end
        if (less !== e.lt) begin
          errors++;
          $display("%0t: less expected %b actual %b", $time, e.lt, less);
        end
        if (equal !== e.eq) begin
          errors++;
          $display("%0t: equal expected %b actual %b", $time, e.eq, equal);
        end
        if (greater !== e.gt) begin
          errors++;
          $display("%0t: greater expected %b actual %b", $time, e.gt, greater);
        end
        if (overflow !== e.ovf) begin
          errors++;
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, overflow);
        end
        if (div_zero !== e.dz) begin
          errors++;
          $display("%0t: div_zero expected %b actual %b", $time, e.dz, div_zero);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    vec_t table_v[$];
    vec_t t;
    alu_out_t w;
    logic [3:0] o;
    logic signed [31:0] a, b;
    int unsigned r;

    // typed rows: {op, a, b, typed, {res, lt, eq, gt, ovf, dz}}
    table_v = '{
      '{fpa_pkg::OP_ADD, fpa_pkg::MAX32, 32'sd1, 1, '{fpa_pkg::MAX32, 0, 0, 1, 1, 0}},
      '{fpa_pkg::OP_ADD, fpa_pkg::MIN32, -32'sd1, 1, '{fpa_pkg::MIN32, 1, 0, 0, 1, 0}},
      '{fpa_pkg::OP_SUB, fpa_pkg::MIN32, 32'sd1, 1, '{fpa_pkg::MIN32, 1, 0, 0, 1, 0}},
      '{fpa_pkg::OP_SUB, fpa_pkg::MAX32, -32'sd1, 1, '{fpa_pkg::MAX32, 0, 0, 1, 1, 0}},
      '{fpa_pkg::OP_MUL, 32'sd256, 32'sd256, 1, '{32'sd256, 0, 1, 0, 0, 0}},
      '{fpa_pkg::OP_MUL, fpa_pkg::MAX32, fpa_pkg::MAX32, 1,
        '{fpa_pkg::MAX32, 0, 1, 0, 1, 0}},
      '{fpa_pkg::OP_MUL, fpa_pkg::MIN32, fpa_pkg::MAX32, 1,
        '{fpa_pkg::MIN32, 1, 0, 0, 1, 0}},
      '{fpa_pkg::OP_MUL, fpa_pkg::MIN32, fpa_pkg::MIN32, 0, '{0, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_MUL, 32'sd1, -32'sd128, 0, '{0, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_DIV, 32'sd256, 32'sd0, 1, '{fpa_pkg::MAX32, 0, 0, 1, 1, 1}},
      '{fpa_pkg::OP_DIV, -32'sd5, 32'sd0, 1, '{fpa_pkg::MIN32, 1, 0, 0, 1, 1}},
      '{fpa_pkg::OP_DIV, 32'sd0, 32'sd0, 1, '{32'sd0, 0, 1, 0, 0, 1}},
      '{fpa_pkg::OP_DIV, fpa_pkg::MIN32, -32'sd1, 0, '{0, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_DIV, 32'sd1, 32'sd512, 0, '{0, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_DIV, fpa_pkg::MAX32, fpa_pkg::MIN32, 0, '{0, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_INC, fpa_pkg::MAX32, 32'sd0, 1, '{fpa_pkg::MAX32, 0, 0, 1, 1, 0}},
      '{fpa_pkg::OP_DEC, fpa_pkg::MIN32, 32'sd0, 1, '{fpa_pkg::MIN32, 1, 0, 0, 1, 0}},
      '{fpa_pkg::OP_MIN, fpa_pkg::MIN32, fpa_pkg::MAX32, 1,
        '{fpa_pkg::MIN32, 1, 0, 0, 0, 0}},
      '{fpa_pkg::OP_MAX, fpa_pkg::MIN32, fpa_pkg::MAX32, 1,
        '{fpa_pkg::MAX32, 1, 0, 0, 0, 0}},
      '{fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0, 1, '{-32'sd1, 1, 0, 0, 0, 0}},
      '{fpa_pkg::OP_TO_INT, fpa_pkg::MAX32, 32'sd0, 1,
        '{32'sh007F_FFFF, 0, 0, 1, 0, 0}},
      '{fpa_pkg::OP_FROM_INT, fpa_pkg::MAX32, 32'sd0, 1,
        '{fpa_pkg::MAX32, 0, 0, 1, 1, 0}},
      '{fpa_pkg::OP_FROM_INT, -32'sd8388608, 32'sd0, 1,
        '{fpa_pkg::MIN32, 1, 0, 0, 0, 0}},
      '{fpa_pkg::OP_COMPARE, 32'sd7, 32'sd7, 1, '{32'sd0, 0, 1, 0, 0, 0}},
      '{4'd15, fpa_pkg::MAX32, fpa_pkg::MIN32, 1, '{32'sd0, 0, 0, 1, 0, 0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_v[i]) begin
      t = table_v[i];
      w = t.typed ? t.want : compute_alu(t.op, t.a, t.b);
      send_item(t.op, t.a, t.b, w);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off until drained once mid-run.
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      r = $urandom_range(0, 19);
      o = (r < 17) ? 4'(r % 11) : 4'($urandom_range(0, 15));
      a = rand_operand();
      b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
      if (o == fpa_pkg::OP_DIV && $urandom_range(0, 9) == 0) b = 0;
      send_item(o, a, b, compute_alu(o, a, b));
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
